[rtl/core/inverse_error_function_unit_macros.svh]
// Assertion macros for the inverse error function unit.
// Needs a clock named clk and an active-high reset named rst in the using scope.
`ifndef INVERSE_ERROR_FUNCTION_UNIT_MACROS_SVH
`define INVERSE_ERROR_FUNCTION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a condition holds at every clock edge out of reset.
`define IEF_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Checks that a consequent holds in the same cycle as its antecedent.
`define IEF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define IEF_ASSERT_ALWAYS(label, expr, msg)
`define IEF_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

[rtl/core/ief_pkg.sv]
// Shared constants and types for the inverse error function unit.
// No dependencies.
package ief_pkg;

  localparam int ARG_W = 32;
  localparam int S_W = 45;
  localparam int P_W = 64;
  localparam int NEGT_W = 48;
  localparam int LOG_STEPS = 32;
  localparam int HORNER_STEPS = 9;
  localparam int POLY_SH = 40;
  localparam int FINAL_SH = 44;

  // ln(2) in Q.56, rounded.
  localparam logic [55:0] LN2_Q56 = 56'hB17217F7D1CF7A;
  // 6.125 in Q.40.
  localparam logic [NEGT_W-1:0] TAIL_LIMIT = NEGT_W'(49) << 37;

  // Coefficients rescaled to the branch variable, Q.40.
  localparam logic signed [P_W-1:0] TAIL_COEF [10] = '{
    (64'sh14deb44 <<< 24), (64'sh1f7c9ae <<< 25), (64'sh147e512 <<< 26),
    (64'sh1dca7de <<< 25), (64'sh19cab92 <<< 24), (64'sh18cc0de <<< 22),
    (64'sh13ca920 <<< 18), -(64'sh10eff66 <<< 19), (64'sh1ae16a4 <<< 15),
    64'sh0
  };

  localparam logic signed [P_W-1:0] MID_COEF [10] = '{
    (64'sh175c000 <<< 15), (64'sh133b402 <<< 17), (64'sh1499232 <<< 17),
    (64'sh1e52cd2 <<< 10), -(64'sh1d70bd0 <<< 16), -(64'sh135be90 <<< 15),
    (64'sh12f6400 <<< 16), (64'sh17a1e50 <<< 15), -(64'sh1db2aee <<< 16),
    (64'sh1c5bf88 <<< 15)
  };

  // Data that rides alongside each polynomial step.
  typedef struct packed {
    logic signed [ARG_W-1:0] a;
    logic                    sp;
    logic                    tail;
    logic signed [S_W-1:0]   s;
    logic signed [P_W-1:0]   p;
  } horner_side_t;

endpackage

[rtl/core/inverse_error_function_unit.sv]
// Inverse error function: each accepted argument word yields its result word, in order.
// Throughput one word per cycle; the whole pipeline holds while a result waits.
// The depth is set by 32 squaring stages of the log and nine four-stage Horner steps.
// Reset clears every valid bit; data registers keep no reset.
// Depends on ief_pkg, ief_mac and inverse_error_function_unit_macros.svh.
`include "inverse_error_function_unit_macros.svh"
module inverse_error_function_unit
  import ief_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [ARG_W-1:0] argument,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ARG_W-1:0] result,
  output logic                    saturated
);

  localparam int HSW = $bits(horner_side_t);

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // Front stages: magnitude, 1 - a*a, leading bit, normalize.
  logic va, vb, vc;
  logic signed [ARG_W-1:0] a_a, a_b, a_c;
  logic sp_a, sp_b, sp_c;
  logic [30:0] ua_a;
  logic [62:0] m_b, m_c;
  logic [5:0] e_c;
  logic [5:0] e_next;
  logic [62:0] sq_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_a <= argument;
      sp_a <= (argument == {1'b1, {(ARG_W-1){1'b0}}});
      ua_a <= argument[ARG_W-1] ? 31'(-argument) : 31'(argument);
    end
  end

  // 1 - a*a kept exactly as a 63-bit integer over 2^62; a zero argument gives 2^62.
  assign sq_diff = (63'(1) << 62) - (63'(ua_a) * 63'(ua_a));

  always_ff @(posedge clk) begin
    if (en) begin
      m_b <= sq_diff;
      a_b <= a_a;
      sp_b <= sp_a;
    end
  end

  // Leading-one position of the mantissa word.
  always_comb begin
    e_next = '0;
    for (int i = 0; i < 63; i++) begin
      if (m_b[i]) begin
        e_next = 6'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_c <= m_b;
      e_c <= e_next;
      a_c <= a_b;
      sp_c <= sp_b;
    end
  end

  // Squaring chain for the fraction of log2; index 0 is the normalized mantissa.
  logic [31:0] sx [LOG_STEPS+1];
  logic [31:0] sf [LOG_STEPS+1];
  logic [5:0] sn [LOG_STEPS+1];
  logic signed [ARG_W-1:0] sa [LOG_STEPS+1];
  logic ssp [LOG_STEPS+1];
  logic sv [LOG_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx[0] <= (e_c >= 6'd31) ? 32'(m_c >> (e_c - 6'd31)) : 32'(m_c << (6'd31 - e_c));
      sf[0] <= '0;
      sn[0] <= 6'd62 - e_c;
      sa[0] <= a_c;
      ssp[0] <= sp_c;
    end
  end

  for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log
    logic [63:0] sq;
    logic [32:0] sh;
    assign sq = 64'(sx[k]) * 64'(sx[k]);
    assign sh = sq[63:31];

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (en) begin
        sv[k+1] <= sv[k];
      end
    end

    // A square of two or more gives a one bit and is halved.
    always_ff @(posedge clk) begin
      if (en) begin
        sx[k+1] <= sh[32] ? sh[32:1] : sh[31:0];
        sf[k+1] <= {sf[k][30:0], sh[32]};
        sn[k+1] <= sn[k];
        sa[k+1] <= sa[k];
        ssp[k+1] <= ssp[k];
      end
    end
  end

  // Log scaling: -t = n*ln2 - f*ln2 in Q.40.
  logic vl1, vl2, vl3;
  logic [55:0] pp_hi;
  logic [63:0] pp_lo;
  logic [45:0] intpart;
  logic [61:0] n_ln2;
  logic [87:0] f_ln2;
  logic [39:0] f_part;
  logic signed [NEGT_W-1:0] negt;
  logic signed [ARG_W-1:0] a_l1, a_l2;
  logic sp_l1, sp_l2;
  logic [NEGT_W-1:0] nz;
  logic tail_sel;
  logic [NEGT_W-1:0] s_mag;
  horner_side_t hs [HORNER_STEPS+1];
  logic hv [HORNER_STEPS+1];

  assign n_ln2 = 62'(sn[LOG_STEPS]) * 62'(LN2_Q56) + (62'(1) << 15);

  always_ff @(posedge clk) begin
    if (rst) begin
      vl1 <= 1'b0;
      vl2 <= 1'b0;
      vl3 <= 1'b0;
    end else if (en) begin
      vl1 <= sv[LOG_STEPS];
      vl2 <= vl1;
      vl3 <= vl2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hi <= 56'(sf[LOG_STEPS]) * 56'(LN2_Q56[55:32]);
      pp_lo <= 64'(sf[LOG_STEPS]) * 64'(LN2_Q56[31:0]);
      intpart <= n_ln2[61:16];
      a_l1 <= sa[LOG_STEPS];
      sp_l1 <= ssp[LOG_STEPS];
    end
  end

  assign f_ln2 = (88'(pp_hi) << 32) + 88'(pp_lo) + (88'(1) << 47);
  assign f_part = f_ln2[87:48];

  always_ff @(posedge clk) begin
    if (en) begin
      negt <= $signed({2'b00, intpart}) - $signed({8'd0, f_part});
      a_l2 <= a_l1;
      sp_l2 <= sp_l1;
    end
  end

  // Branch choice and the scaled polynomial variable.
  always_comb begin
    nz = negt[NEGT_W-1] ? '0 : negt;
    tail_sel = nz > TAIL_LIMIT;
    s_mag = tail_sel ? ((nz + NEGT_W'(16)) >> 5) : ((nz + NEGT_W'(4)) >> 3);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hs[0].a <= a_l2;
      hs[0].sp <= sp_l2;
      hs[0].tail <= tail_sel;
      hs[0].s <= -$signed(S_W'(s_mag));
      hs[0].p <= tail_sel ? TAIL_COEF[0] : MID_COEF[0];
    end
  end
  assign hv[0] = vl3;

  // Horner steps; the tail polynomial has one coefficient fewer and skips the last.
  for (genvar k = 1; k <= HORNER_STEPS; k++) begin : g_horner
    horner_side_t so;
    logic signed [63:0] hz;
    logic signed [63:0] coef;

    assign coef = hs[k-1].tail ? TAIL_COEF[k] : MID_COEF[k];

    ief_mac #(
      .XW(P_W),
      .YW(S_W),
      .SH(POLY_SH),
      .SW(HSW)
    ) u_step (
      .clk(clk),
      .rst(rst),
      .en(en),
      .in_valid(hv[k-1]),
      .x(hs[k-1].p),
      .y(hs[k-1].s),
      .c(coef),
      .side_in(hs[k-1]),
      .out_valid(hv[k]),
      .z(hz),
      .side_out(so)
    );

    always_comb begin
      hs[k] = so;
      if (k == HORNER_STEPS && so.tail) begin
        hs[k].p = so.p;
      end else begin
        hs[k].p = hz;
      end
    end
  end

  // Final product a * p in Q.27.
  logic vf;
  logic signed [63:0] rz;
  logic sp_f;

  ief_mac #(
    .XW(ARG_W),
    .YW(P_W),
    .SH(FINAL_SH),
    .SW(1)
  ) u_final (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(hv[HORNER_STEPS]),
    .x(hs[HORNER_STEPS].a),
    .y(hs[HORNER_STEPS].p),
    .c(64'sd0),
    .side_in(hs[HORNER_STEPS].sp),
    .out_valid(vf),
    .z(rz),
    .side_out(sp_f)
  );

  // Output register with clamping to the 32-bit range.
  logic signed [ARG_W-1:0] result_next;
  logic saturated_next;
  localparam logic signed [63:0] R_MAX = 64'sh7FFF_FFFF;
  localparam logic signed [63:0] R_MIN = -64'sh8000_0000;

  always_comb begin
    if (sp_f) begin
      result_next = {1'b1, {(ARG_W-1){1'b0}}};
      saturated_next = 1'b1;
    end else if (rz > R_MAX) begin
      result_next = R_MAX[ARG_W-1:0];
      saturated_next = 1'b1;
    end else if (rz < R_MIN) begin
      result_next = R_MIN[ARG_W-1:0];
      saturated_next = 1'b1;
    end else begin
      result_next = rz[ARG_W-1:0];
      saturated_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
      saturated <= saturated_next;
    end
  end

  // A clamped word is always one of the two range ends.
  `IEF_ASSERT_IMPL(a_sat_end, out_valid && saturated, result == 32'sh7FFF_FFFF || result == 32'sh8000_0000, "saturated word not at a range end")
  // The normalized mantissa always has its leading bit set.
  `IEF_ASSERT_IMPL(a_norm, sv[0], sx[0][31], "mantissa not normalized")
  // The polynomial variable is never positive.
  `IEF_ASSERT_IMPL(a_s_sign, hv[0], hs[0].s[S_W-1] || hs[0].s == '0, "polynomial variable positive")

endmodule

[rtl/core/ief_mac.sv]
// Pipelined multiply, round, shift, clamp and add: z = round(x*y / 2^SH) + c.
// Depends on ief_pkg for nothing but house constants; four register stages.
module ief_mac
  import ief_pkg::*;
#(
  parameter int XW = 64,
  parameter int YW = S_W,
  parameter int SH = POLY_SH,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] x,
  input  logic signed [YW-1:0] y,
  input  logic signed [63:0]   c,
  input  logic [SW-1:0]        side_in,
  output logic                 out_valid,
  output logic signed [63:0]   z,
  output logic [SW-1:0]        side_out
);

  localparam int XL = XW / 2;
  localparam int XH = XW - XL;
  localparam int YL = YW / 2;
  localparam int YH = YW - YL;

  logic [3:0] v;
  logic [XW-1:0] ax1;
  logic [YW-1:0] ay1;
  logic neg1, neg2, neg3;
  logic signed [63:0] c1, c2, c3;
  logic [SW-1:0] sd1, sd2, sd3;
  logic [XL+YL-1:0] p_ll;
  logic [XL+YH-1:0] p_lh;
  logic [XH+YL-1:0] p_hl;
  logic [XH+YH-1:0] p_hh;
  logic [127:0] r3;
  logic [127:0] q;
  logic [63:0] mag;

  // Valid bits follow the data through the four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], in_valid};
    end
  end
  assign out_valid = v[3];

  // Stage one takes magnitudes and the product sign.
  always_ff @(posedge clk) begin
    if (en) begin
      ax1 <= x[XW-1] ? XW'(-x) : XW'(x);
      ay1 <= y[YW-1] ? YW'(-y) : YW'(y);
      neg1 <= x[XW-1] ^ y[YW-1];
      c1 <= c;
      sd1 <= side_in;
    end
  end

  // Stage two forms four partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      p_ll <= ax1[XL-1:0] * ay1[YL-1:0];
      p_lh <= ax1[XL-1:0] * ay1[YW-1:YL];
      p_hl <= ax1[XW-1:XL] * ay1[YL-1:0];
      p_hh <= ax1[XW-1:XL] * ay1[YW-1:YL];
      neg2 <= neg1;
      c2 <= c1;
      sd2 <= sd1;
    end
  end

  // Stage three sums the partials and adds the rounding half.
  always_ff @(posedge clk) begin
    if (en) begin
      r3 <= 128'(p_ll) + (128'(p_lh) << YL) + (128'(p_hl) << XL)
          + (128'(p_hh) << (XL + YL)) + (128'(1) << (SH - 1));
      neg3 <= neg2;
      c3 <= c2;
      sd3 <= sd2;
    end
  end

  // Stage four shifts, clamps the magnitude, restores the sign and adds c.
  always_comb begin
    q = r3 >> SH;
    mag = (|q[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z <= (neg3 ? -$signed(mag) : $signed(mag)) + c3;
      side_out <= sd3;
    end
  end

endmodule
